// ----- rtl/nsl_pkg.sv -----
// nsl_pkg: shared constants, types and helpers for the nearest-seed labeler.
// No dependencies; used by every module under rtl/.
`default_nettype none

package nsl_pkg;

    localparam int MAX_SEEDS  = 256;
    localparam int COORD_BITS = 12;

    // Port widths fixed by the interface
    localparam int IN_CRD_W  = 12;
    localparam int IN_SLOT_W = 8;
    localparam int CFG_W     = 9;
    localparam int OUT_IDX_W = 8;
    localparam int OUT_DST_W = 25;

    // Derived widths
    localparam int IDX_W   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEEDS + 1);
    localparam int ENTRY_W = 2 * COORD_BITS;
    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam int CMP_W   = (DIST_W > OUT_DST_W) ? DIST_W : OUT_DST_W;

    localparam logic [CMP_W-1:0] DIST_SAT = CMP_W'((64'd1 << OUT_DST_W) - 64'd1);

    // func codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [DIST_W-1:0]     t_dist;

    // Tag that travels alongside a seed through the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    // Clamp a full-width distance to the output field
    function automatic logic [OUT_DST_W-1:0] sat_dist(input t_dist d);
        logic [CMP_W-1:0] w;
        w = CMP_W'(d);
        if (w > DIST_SAT) begin
            return '1;
        end
        return OUT_DST_W'(w);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nearest_seed_pixel_labeler_core.sv -----
// nearest_seed_pixel_labeler_core: top level, scan sequencer and best-seed tracker.
// Depends on nsl_pkg, nsl_seed_ram and nsl_dist_unit.
//
// Load: no result; busy stays low. Query with N = min(sample_count,
// MAX_SEEDS) seeds: busy is high while the N seeds are read from seed memory,
// one per cycle, and pass the diff and square register stages; the strobe
// comes from the output register as busy falls, and the next start transfer
// is taken from then on. With N = 0 the not-found result comes the cycle
// after start. The receiver cannot stall.
// Reset (synchronous, active low) clears sample_count and the sequencer; the
// seed memory is not cleared and a slot must be loaded before it is scanned.
`default_nettype none

module nearest_seed_pixel_labeler_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command channel
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic                            i_func,
    input  wire logic [nsl_pkg::IN_CRD_W-1:0]    i_coord_x,
    input  wire logic [nsl_pkg::IN_CRD_W-1:0]    i_coord_y,
    input  wire logic [nsl_pkg::IN_SLOT_W-1:0]   i_seed_slot,
    // configuration write channel (sample_count)
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [nsl_pkg::CFG_W-1:0]       i_cfg_data,
    // result
    output logic                                 o_strobe,
    output logic                                 o_found,
    output logic      [nsl_pkg::OUT_IDX_W-1:0]   o_nearest_index,
    output logic      [nsl_pkg::OUT_DST_W-1:0]   o_distance_sq
);

    localparam int IDX_W = nsl_pkg::IDX_W;
    localparam int CNT_W = nsl_pkg::CNT_W;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                      r_state, n_state;
    logic [nsl_pkg::CFG_W-1:0] r_sample_count;

    // query context
    nsl_pkg::t_coord   r_qx, r_qy;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rd_idx;
    nsl_pkg::t_tag     r_rd_tag;

    // running best
    logic              r_have;
    nsl_pkg::t_dist    r_best_d;
    logic [IDX_W-1:0]  r_best_k;

    // output registers
    logic                          r_strobe, n_strobe;
    logic                          r_found;
    logic [nsl_pkg::OUT_IDX_W-1:0] r_nidx;
    logic [nsl_pkg::OUT_DST_W-1:0] r_dist;

    // datapath nets
    logic                          accept, is_load, is_query;
    logic                          slot_ok;
    logic [CNT_W-1:0]              clamped_cnt;
    logic                          rd_en, rd_last;
    logic [nsl_pkg::ENTRY_W-1:0]   wr_entry, rd_entry;
    nsl_pkg::t_tag                 du_tag;
    nsl_pkg::t_dist                du_dist;
    logic                          take;
    nsl_pkg::t_dist                sel_d;
    logic [IDX_W-1:0]              sel_k;

    assign o_busy      = (r_state == ST_SCAN);
    assign o_cfg_ready = (r_state == ST_IDLE);

    assign accept   = i_start && !o_busy;
    assign is_load  = accept && (i_func == nsl_pkg::FUNC_LOAD);
    assign is_query = accept && (i_func == nsl_pkg::FUNC_QUERY);

    // loads beyond the store are dropped
    assign slot_ok  = ({24'd0, i_seed_slot} < 32'(nsl_pkg::MAX_SEEDS));
    assign wr_entry = {nsl_pkg::COORD_BITS'(i_coord_y), nsl_pkg::COORD_BITS'(i_coord_x)};

    // count above the store depth scans the whole store
    assign clamped_cnt = ({23'd0, r_sample_count} > 32'(nsl_pkg::MAX_SEEDS))
                       ? CNT_W'(nsl_pkg::MAX_SEEDS) : CNT_W'(r_sample_count);

    // one read per cycle while slots remain
    assign rd_en   = (r_state == ST_SCAN) && (r_rd_idx < r_count);
    assign rd_last = (r_rd_idx == (r_count - CNT_W'(1)));

    nsl_seed_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (is_load && slot_ok),
        .i_waddr (IDX_W'(i_seed_slot)),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    nsl_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_entry (rd_entry),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_tag   (du_tag),
        .o_dist  (du_dist)
    );

    // strict less-than keeps the lower slot on ties (scan is ascending)
    assign take  = du_tag.valid && (!r_have || (du_dist < r_best_d));
    assign sel_d = take ? du_dist : r_best_d;
    assign sel_k = take ? du_tag.idx : r_best_k;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (is_query) begin
                    if (clamped_cnt == '0) begin
                        n_strobe = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (du_tag.valid && du_tag.last) begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sample_count <= '0;
            r_strobe       <= 1'b0;
            r_have         <= 1'b0;
            r_rd_tag.valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_sample_count <= i_cfg_data;
            end
            r_rd_tag.valid <= rd_en;
            if (is_query || (du_tag.valid && du_tag.last)) begin
                r_have <= 1'b0;
            end else if (du_tag.valid) begin
                r_have <= 1'b1;
            end
        end
        r_rd_tag.last <= rd_last;
        r_rd_tag.idx  <= r_rd_idx[IDX_W-1:0];
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_qx     <= nsl_pkg::COORD_BITS'(i_coord_x);
            r_qy     <= nsl_pkg::COORD_BITS'(i_coord_y);
            r_count  <= clamped_cnt;
            r_rd_idx <= '0;
        end else if (rd_en) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
        if (du_tag.valid) begin
            r_best_d <= sel_d;
            r_best_k <= sel_k;
        end
        if (n_strobe) begin
            if (r_state == ST_IDLE) begin
                // no seeds in use
                r_found <= 1'b0;
                r_nidx  <= '0;
                r_dist  <= '0;
            end else begin
                r_found <= 1'b1;
                r_nidx  <= nsl_pkg::OUT_IDX_W'(sel_k);
                r_dist  <= nsl_pkg::sat_dist(sel_d);
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_found         = r_found;
    assign o_nearest_index = r_nidx;
    assign o_distance_sq   = r_dist;

endmodule

`default_nettype wire

// ----- rtl/nsl_seed_ram.sv -----
// nsl_seed_ram: seed coordinate store, one write and one registered read port.
// Depends on nsl_pkg for depth and entry width.
`default_nettype none

module nsl_seed_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [nsl_pkg::IDX_W-1:0]   i_waddr,
    input  wire logic [nsl_pkg::ENTRY_W-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [nsl_pkg::IDX_W-1:0]   i_raddr,
    output logic      [nsl_pkg::ENTRY_W-1:0] o_rdata
);

    logic [nsl_pkg::ENTRY_W-1:0] mem [nsl_pkg::MAX_SEEDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nsl_dist_unit.sv -----
// nsl_dist_unit: two-stage squared-distance pipeline (abs diff, then square+sum).
// Depends on nsl_pkg for coordinate widths and the t_tag struct.
`default_nettype none

module nsl_dist_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire nsl_pkg::t_tag               i_tag,
    input  wire logic [nsl_pkg::ENTRY_W-1:0] i_entry,
    input  wire nsl_pkg::t_coord             i_qx,
    input  wire nsl_pkg::t_coord             i_qy,
    output nsl_pkg::t_tag                    o_tag,
    output nsl_pkg::t_dist                   o_dist
);

    localparam int CB = nsl_pkg::COORD_BITS;

    nsl_pkg::t_coord sx, sy, n_dx, n_dy;
    nsl_pkg::t_coord r_dx, r_dy;
    nsl_pkg::t_tag   r_tag_a, r_tag_b;
    logic [2*CB-1:0] sq_x, sq_y;
    nsl_pkg::t_dist  r_dist;

    assign sx   = i_entry[CB-1:0];
    assign sy   = i_entry[2*CB-1:CB];
    assign n_dx = (sx >= i_qx) ? (sx - i_qx) : (i_qx - sx);
    assign n_dy = (sy >= i_qy) ? (sy - i_qy) : (i_qy - sy);

    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a.valid <= 1'b0;
            r_tag_b.valid <= 1'b0;
        end else begin
            r_tag_a.valid <= i_tag.valid;
            r_tag_b.valid <= r_tag_a.valid;
        end
        r_tag_a.last <= i_tag.last;
        r_tag_a.idx  <= i_tag.idx;
        r_tag_b.last <= r_tag_a.last;
        r_tag_b.idx  <= r_tag_a.idx;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_dist <= nsl_pkg::DIST_W'(sq_x) + nsl_pkg::DIST_W'(sq_y);
    end

    assign o_tag  = r_tag_b;
    assign o_dist = r_dist;

endmodule

`default_nettype wire

// ----- tb/sv/nearest_seed_pixel_labeler_core_tb.sv -----
`timescale 1ns / 100ps
// nearest_seed_pixel_labeler_core_tb: self-checking bench for the nearest-seed labeler.
// Depends on nsl_pkg and nearest_seed_pixel_labeler_core; drives seed loads, pixel
// queries and sample_count writes, and checks every label against its own scan.

module nearest_seed_pixel_labeler_core_tb;

    localparam int  MAX_SEEDS    = nsl_pkg::MAX_SEEDS;
    localparam int  IN_CRD_W     = nsl_pkg::IN_CRD_W;
    localparam int  IN_SLOT_W    = nsl_pkg::IN_SLOT_W;
    localparam int  CFG_W        = nsl_pkg::CFG_W;
    localparam int  OUT_IDX_W    = nsl_pkg::OUT_IDX_W;
    localparam int  OUT_DST_W    = nsl_pkg::OUT_DST_W;

    localparam int  CLK_PERIOD   = 8;
    localparam int  RESET_CYCLES = 6;
    localparam int  LOAD_SETTLE  = 4;            // trailing settle time after a load
    localparam int  END_SETTLE   = MAX_SEEDS + 8; // longest query plus margin
    localparam int  CYCLE_LIMIT  = 2_000_000;
    localparam int  REPORT_MAX   = 10;
    localparam logic [OUT_DST_W-1:0] DSQ_ALL_ONES = '1;

    typedef nsl_pkg::t_coord t_coord;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic [OUT_DST_W-1:0] dsq;
    } t_label;

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_start     = 1'b0;
    logic                   i_func      = nsl_pkg::FUNC_LOAD;
    logic [IN_CRD_W-1:0]    i_coord_x   = '0;
    logic [IN_CRD_W-1:0]    i_coord_y   = '0;
    logic [IN_SLOT_W-1:0]   i_seed_slot = '0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data  = '0;
    logic                   o_busy;
    logic                   o_cfg_ready;
    logic                   o_strobe;
    logic                   o_found;
    logic [OUT_IDX_W-1:0]   o_nearest_index;
    logic [OUT_DST_W-1:0]   o_distance_sq;

    nearest_seed_pixel_labeler_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_func          (i_func),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_seed_slot     (i_seed_slot),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_found         (o_found),
        .o_nearest_index (o_nearest_index),
        .o_distance_sq   (o_distance_sq)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow state of the labeler: seed coordinates and scan count
    // ---------------------------------------------------------------
    t_coord          seed_x_mem [MAX_SEEDS];
    t_coord          seed_y_mem [MAX_SEEDS];
    logic [CFG_W-1:0] scan_count = '0;   // reset value of sample_count

    t_label pending_labels [$];          // labels owed by accepted queries

    int sender_idle_pct = 0;
    int loads_sent      = 0;
    int queries_sent    = 0;
    int cfg_writes      = 0;
    int labels_checked  = 0;
    int label_errors    = 0;
    int cycle_count     = 0;

    // Exact scan of slots 0 .. min(scan_count, MAX_SEEDS)-1; strict less-than
    // keeps the lowest slot on a tie. Distance saturates at the port width.
    function automatic t_label nearest_seed_lookup(input t_coord px,
                                                   input t_coord py);
        t_label          lbl;
        int unsigned     n;
        longint          dx;
        longint          dy;
        longint unsigned d;
        longint unsigned best;
        lbl  = '0;
        best = 0;
        n    = (scan_count > MAX_SEEDS) ? MAX_SEEDS : scan_count;
        for (int unsigned k = 0; k < n; k++) begin
            dx = longint'(seed_x_mem[k]) - longint'(px);
            dy = longint'(seed_y_mem[k]) - longint'(py);
            d  = longint'(dx * dx + dy * dy);
            if (!lbl.found || d < best) begin
                lbl.found = 1'b1;
                lbl.index = OUT_IDX_W'(k);
                best      = d;
            end
        end
        lbl.dsq = (best > longint'(DSQ_ALL_ONES)) ? DSQ_ALL_ONES : OUT_DST_W'(best);
        return lbl;
    endfunction

    // Coordinates: full range, the two extremes, or a tight cluster so that
    // equal distances (and thus ties) come up often.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 3))
            0:       return t_coord'($urandom_range(0, 4095));
            1:       return $urandom_range(0, 1) ? t_coord'(4095) : t_coord'(0);
            default: return t_coord'(2000 + $urandom_range(0, 15));
        endcase
    endfunction

    // Mostly small scans; a few empty, full or over-range counts
    function automatic logic [CFG_W-1:0] pick_scan_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 20) return CFG_W'($urandom_range(MAX_SEEDS, 511));
        if (r < 30) return CFG_W'($urandom_range(17, MAX_SEEDS - 1));
        return CFG_W'($urandom_range(1, 16));
    endfunction

    // ---------------------------------------------------------------
    // Command transfer: optional idle gap, then hold start until accepted.
    // start is left high after the transfer; the next negedge action
    // (another item, an idle cycle or wait_idle) takes it down.
    // ---------------------------------------------------------------
    task automatic issue_item(input logic func, input t_coord x, input t_coord y,
                              input logic [IN_SLOT_W-1:0] slot);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start     <= 1'b1;
        i_func      <= func;
        i_coord_x   <= x;
        i_coord_y   <= y;
        i_seed_slot <= slot;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (func == nsl_pkg::FUNC_LOAD) begin
            seed_x_mem[slot] = x;
            seed_y_mem[slot] = y;
            loads_sent++;
        end else begin
            pending_labels = {pending_labels, nearest_seed_lookup(x, y)};
            queries_sent++;
        end
    endtask

    task automatic load_seed(input logic [IN_SLOT_W-1:0] slot, input t_coord x,
                             input t_coord y);
        issue_item(nsl_pkg::FUNC_LOAD, x, y, slot);
    endtask

    task automatic query_pixel(input t_coord x, input t_coord y);
        issue_item(nsl_pkg::FUNC_QUERY, x, y, IN_SLOT_W'($urandom_range(0, 255)));
    endtask

    // Drop start, let every owed label arrive, then give a trailing load time
    task automatic wait_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_scan_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        scan_count = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result checker: one label per strobe, in order
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_label want;
        if (i_rst_n && o_strobe) begin
            if (pending_labels.size() == 0) begin
                label_errors++;
                if (label_errors <= REPORT_MAX)
                    $display("ERROR: unexpected label found=%0d idx=%0d dsq=%0d",
                             o_found, o_nearest_index, o_distance_sq);
            end else begin
                want = pending_labels.pop_front();
                labels_checked++;
                if (o_found !== want.found || o_nearest_index !== want.index ||
                    o_distance_sq !== want.dsq) begin
                    label_errors++;
                    if (label_errors <= REPORT_MAX)
                        $display({"ERROR: label %0d exp found=%0d idx=%0d dsq=%0d,",
                                  " got found=%0d idx=%0d dsq=%0d"},
                                 labels_checked, want.found, want.index, want.dsq,
                                 o_found, o_nearest_index, o_distance_sq);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("nearest_seed_pixel_labeler_core_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // sample_count is 0 out of reset: a query must come back not found
    task automatic test_empty_store();
        query_pixel(t_coord'(4095), t_coord'(0));
        load_seed(IN_SLOT_W'(255), t_coord'(1234), t_coord'(2345));
        wait_idle();
    endtask

    // Corner seeds, a duplicate seed (tie on zero distance), an exact tie
    // between two distinct seeds, and the largest possible distance.
    task automatic test_corners_and_ties();
        load_seed(IN_SLOT_W'(0), t_coord'(0),    t_coord'(0));
        load_seed(IN_SLOT_W'(1), t_coord'(4095), t_coord'(4095));
        load_seed(IN_SLOT_W'(2), t_coord'(0),    t_coord'(4095));
        load_seed(IN_SLOT_W'(3), t_coord'(4095), t_coord'(0));
        load_seed(IN_SLOT_W'(4), t_coord'(4095), t_coord'(4095));
        load_seed(IN_SLOT_W'(5), t_coord'(10),   t_coord'(0));
        wait_idle();
        write_scan_count(CFG_W'(6));
        query_pixel(t_coord'(0),    t_coord'(0));
        query_pixel(t_coord'(4095), t_coord'(4095));
        query_pixel(t_coord'(2048), t_coord'(2048));
        query_pixel(t_coord'(5),    t_coord'(0));
        query_pixel(t_coord'(0),    t_coord'(2048));
        wait_idle();
        // single seed at the origin against the far corner
        write_scan_count(CFG_W'(1));
        query_pixel(t_coord'(4095), t_coord'(4095));
        query_pixel(t_coord'(2730), t_coord'(1365));
        wait_idle();
    endtask

    // Every slot gets written so later scans of any length stay legal
    task automatic fill_seed_store();
        for (int s = 0; s < MAX_SEEDS; s++)
            load_seed(IN_SLOT_W'(s), rand_coord(), rand_coord());
        wait_idle();
    endtask

    // Full-depth scan, an over-range count clamped to full depth, then empty
    task automatic test_count_extremes();
        write_scan_count(CFG_W'(MAX_SEEDS));
        query_pixel(t_coord'(0), t_coord'(4095));
        query_pixel(seed_x_mem[MAX_SEEDS-1], seed_y_mem[MAX_SEEDS-1]);
        wait_idle();
        write_scan_count(CFG_W'(511));
        query_pixel(t_coord'(4095), t_coord'(0));
        query_pixel(rand_coord(), rand_coord());
        wait_idle();
        write_scan_count(CFG_W'(0));
        query_pixel(t_coord'(2048), t_coord'(2048));
        wait_idle();
    endtask

    // Bursts of loads and queries under one sample_count each. Loads lean
    // toward slots that the current count scans; some queries sit exactly
    // on a stored seed.
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int          remaining;
        int          burst;
        int unsigned n;
        int unsigned pick;
        remaining       = n_items;
        sender_idle_pct = idle_pct;
        while (remaining > 0) begin
            wait_idle();
            write_scan_count(pick_scan_count());
            n     = (scan_count > MAX_SEEDS) ? MAX_SEEDS : scan_count;
            burst = $urandom_range(10, 40);
            for (int i = 0; i < burst && remaining > 0; i++) begin
                if ($urandom_range(0, 99) < 30) begin
                    if (n > 0 && $urandom_range(0, 99) < 60)
                        pick = $urandom_range(0, n - 1);
                    else
                        pick = $urandom_range(0, MAX_SEEDS - 1);
                    load_seed(IN_SLOT_W'(pick), rand_coord(), rand_coord());
                end else if ($urandom_range(0, 99) < 15) begin
                    pick = $urandom_range(0, MAX_SEEDS - 1);
                    query_pixel(seed_x_mem[pick], seed_y_mem[pick]);
                end else begin
                    query_pixel(rand_coord(), rand_coord());
                end
                remaining--;
            end
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_corners_and_ties();
        fill_seed_store();
        test_count_extremes();
        test_random_traffic(7, 160);
        test_random_traffic(69, 160);
        test_random_traffic(0, 160);

        repeat (END_SETTLE) @(posedge i_clk);
        if (pending_labels.size() != 0) begin
            label_errors++;
            $display("ERROR: %0d labels never arrived", pending_labels.size());
        end

        $display("Run covered %0d seed loads and %0d pixel queries over %0d %s",
                 loads_sent, queries_sent, cfg_writes, "sample_count settings,");
        $display("with %0d labels checked and %0d errors.", labels_checked, label_errors);
        if (label_errors == 0) begin
            $display("nearest_seed_pixel_labeler_core_tb: PASS");
        end else begin
            $display("nearest_seed_pixel_labeler_core_tb: FAIL");
        end
        $finish;
    end

endmodule
